// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/lsra_pkg.sv =====
package lsra_pkg;

    localparam int ID_W  = 16;
    localparam int POS_W = 16;
    localparam int REG_W = 5;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [REG_W-1:0] t_reg_idx;

    // Allocation sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_RSV,
        S_SPILL,
        S_VICTIM,
        S_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic free_step;
        logic put_rsv;
        logic spill_step;
        logic put_victim;
        logic push;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic free_hit;
        logic at_last_ord;
        logic at_last;
        logic out_busy;
    } t_dp_status;

endpackage

// ===== rtl/lsra_ctrl.sv =====
module lsra_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    output lsra_pkg::t_dp_cmd     o_cmd,
    input  lsra_pkg::t_dp_status  i_status
);
    import lsra_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_FREE;
            end
            S_FREE: begin
                if (i_status.free_hit) begin
                    n_state = S_OUT;
                end else if (i_status.at_last_ord) begin
                    n_state = S_RSV;
                end
            end
            S_RSV: begin
                n_state = S_SPILL;
            end
            S_SPILL: begin
                if (i_status.at_last) n_state = S_VICTIM;
            end
            S_VICTIM: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Command decode
    always_comb begin
        o_ready          = (r_state == S_IDLE);
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_valid;
        o_cmd.free_step  = (r_state == S_FREE);
        o_cmd.put_rsv    = (r_state == S_RSV);
        o_cmd.spill_step = (r_state == S_SPILL);
        o_cmd.put_victim = (r_state == S_VICTIM);
        o_cmd.push       = (r_state == S_OUT) && !i_status.out_busy;
    end

endmodule

// ===== rtl/lsra_dp.sv =====
module lsra_dp #(
    parameter int REGISTER_COUNT = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lsra_pkg::t_dp_cmd     i_cmd,
    output lsra_pkg::t_dp_status  o_status,
    input  logic                  i_first_of_function,
    input  lsra_pkg::t_id         i_interval_id,
    input  lsra_pkg::t_pos        i_def_position,
    input  lsra_pkg::t_pos        i_last_use_position,
    input  logic                  i_ready,
    output logic                  o_valid,
    output lsra_pkg::t_reg_idx    o_assigned_register,
    output logic                  o_overflow,
    output logic                  o_evicted_valid,
    output lsra_pkg::t_id         o_evicted_id
);
    import lsra_pkg::*;

    localparam int IDX_W = $clog2(REGISTER_COUNT);
    localparam logic [IDX_W-1:0] LAST_ORD = IDX_W'(REGISTER_COUNT - 2);
    localparam logic [IDX_W-1:0] LAST     = IDX_W'(REGISTER_COUNT - 1);

    // Slot file
    logic [REGISTER_COUNT-1:0] r_occ;
    t_id                       r_slot_id  [REGISTER_COUNT];
    t_pos                      r_slot_end [REGISTER_COUNT];

    // Current transaction
    t_id              r_id;
    t_pos             r_def;
    t_pos             r_end;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;

    // Spill search
    logic [IDX_W-1:0] r_best_idx;
    t_pos             r_best_end;
    t_id              r_best_id;

    // Result and output registers
    t_reg_idx r_res_reg;
    logic     r_res_ovf;
    t_id      r_res_id;
    logic     r_out_valid;
    t_reg_idx r_out_reg;
    logic     r_out_ovf;
    t_id      r_out_id;

    t_pos             w_cur_end;
    t_id              w_cur_id;
    logic             w_hit;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic             w_better;

    // Slot under the scan pointer
    assign w_cur_end = r_slot_end[r_idx];
    assign w_cur_id  = r_slot_id[r_idx];
    assign w_hit     = !r_occ[r_idx] || (w_cur_end <= r_def);
    assign w_better  = (r_idx == '0) || (w_cur_end > r_best_end);

    // Status
    assign o_status.free_hit    = w_hit;
    assign o_status.at_last_ord = (r_idx == LAST_ORD);
    assign o_status.at_last     = (r_idx == LAST);
    assign o_status.out_busy    = r_out_valid && !i_ready;

    // Single write port into the slot file
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        if (i_cmd.free_step && w_hit) begin
            w_we = 1'b1;
        end else if (i_cmd.put_rsv) begin
            w_we    = 1'b1;
            w_waddr = LAST;
        end else if (i_cmd.put_victim) begin
            w_we    = 1'b1;
            w_waddr = r_best_idx;
        end
    end

    // Scan pointer
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.load || i_cmd.put_rsv) begin
            n_idx = '0;
        end else if ((i_cmd.free_step && !w_hit) || (i_cmd.spill_step && r_idx != LAST)) begin
            n_idx = r_idx + 1'b1;
        end
    end

    // Occupancy and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_first_of_function) begin
                r_occ <= '0;
            end else if (w_we) begin
                r_occ[w_waddr] <= 1'b1;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_id  <= i_interval_id;
            r_def <= i_def_position;
            r_end <= i_last_use_position;
        end
        if (w_we) begin
            r_slot_id[w_waddr]  <= r_id;
            r_slot_end[w_waddr] <= r_end;
        end
        // free slot found
        if (i_cmd.free_step && w_hit) begin
            r_res_reg <= t_reg_idx'(r_idx);
            r_res_ovf <= 1'b0;
            r_res_id  <= '0;
        end
        // greatest last use, first index wins ties
        if (i_cmd.spill_step && w_better) begin
            r_best_idx <= r_idx;
            r_best_end <= w_cur_end;
            r_best_id  <= w_cur_id;
        end
        if (i_cmd.put_victim) begin
            r_res_reg <= t_reg_idx'(r_best_idx);
            r_res_ovf <= 1'b1;
            r_res_id  <= r_best_id;
        end
        if (i_cmd.push) begin
            r_out_reg <= r_res_reg;
            r_out_ovf <= r_res_ovf;
            r_out_id  <= r_res_id;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_assigned_register = r_out_reg;
    assign o_overflow          = r_out_ovf;
    assign o_evicted_valid     = r_out_ovf;
    assign o_evicted_id        = r_out_id;

endmodule

// ===== rtl/linear_scan_register_allocator_core.sv =====
// Flow: a free scan over the ordinary slots ends on the first free hit; a
// spill adds a reserved-slot write, a full spill scan and a victim write.
// Throughput: one transaction at a time; the slot scan visits one slot per
// cycle, so a spill costs two passes, and the result may wait on i_ready
// before the next acceptance.
// Reset (i_rst_n low, synchronous): all slots empty, output register empty.
module linear_scan_register_allocator_core #(
    parameter int REGISTER_COUNT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_first_of_function,
    input  lsra_pkg::t_id      i_interval_id,
    input  lsra_pkg::t_pos     i_def_position,
    input  lsra_pkg::t_pos     i_last_use_position,
    output logic               o_valid,
    input  logic               i_ready,
    output lsra_pkg::t_reg_idx o_assigned_register,
    output logic               o_overflow,
    output logic               o_evicted_valid,
    output lsra_pkg::t_id      o_evicted_id
);
    import lsra_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer
    lsra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    // Slot file, scan and output register
    lsra_dp #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_first_of_function (i_first_of_function),
        .i_interval_id       (i_interval_id),
        .i_def_position      (i_def_position),
        .i_last_use_position (i_last_use_position),
        .i_ready             (i_ready),
        .o_valid             (o_valid),
        .o_assigned_register (o_assigned_register),
        .o_overflow          (o_overflow),
        .o_evicted_valid     (o_evicted_valid),
        .o_evicted_id        (o_evicted_id)
    );

endmodule

// ===== rtl/lsra_checker.sv =====
`include "assert_macros.svh"

module lsra_checker #(
    parameter int REGISTER_COUNT = 8
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               i_first_of_function,
    input lsra_pkg::t_id      i_interval_id,
    input lsra_pkg::t_pos     i_def_position,
    input lsra_pkg::t_pos     i_last_use_position,
    input logic               o_valid,
    input logic               i_ready,
    input lsra_pkg::t_reg_idx o_assigned_register,
    input logic               o_overflow,
    input logic               o_evicted_valid,
    input lsra_pkg::t_id      o_evicted_id
);
    import lsra_pkg::*;

    localparam t_reg_idx RSV_REG = t_reg_idx'(REGISTER_COUNT - 1);

    // a stalled result holds its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_evicted_id) && $stable(o_assigned_register))

    // on a spill, o_evicted_valid and o_overflow are raised together
    `ASSERT_IMPLIES(a_spill_flags, i_clk, i_rst_n, o_valid, o_evicted_valid == o_overflow)

    // no spilled id without a spill
    `ASSERT_IMPLIES(a_no_evict_id, i_clk, i_rst_n, o_valid && !o_evicted_valid, o_evicted_id == '0)

    // the reserved register is only handed out on a spill
    `ASSERT_IMPLIES(a_rsv_only_spill, i_clk, i_rst_n, o_valid && !o_overflow, o_assigned_register < RSV_REG)

    // one transaction in flight: intake closes after an acceptance
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule

bind linear_scan_register_allocator_core lsra_checker #(
    .REGISTER_COUNT (REGISTER_COUNT)
) u_lsra_checker (.*);
